// ===== rtl/core/bps_pkg.sv =====
// Shared types and constants of the Blinn-Phong fragment shader.
// Holds the beat structures, register indexes and the Q1.16 multiply helper.
// No dependencies.
package bps_pkg;

  localparam int VECTOR_WIDTH    = 16;
  localparam int COLOR_WIDTH     = 16;
  localparam int SHIN_WIDTH      = 15;
  localparam int SHIN_FRAC_BITS  = 6;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int COS_WIDTH       = 17;

  localparam logic [COS_WIDTH-1:0] ONE_Q16 = 17'h10000;

  localparam logic [COLOR_WIDTH-1:0] COLOR_ONE  = {1'b1, {(COLOR_WIDTH-1){1'b0}}};
  localparam logic [COLOR_WIDTH-1:0] COLOR_HALF = {2'b01, {(COLOR_WIDTH-2){1'b0}}};
  localparam logic [COLOR_WIDTH-1:0] COLOR_ZERO = '0;
  localparam logic [SHIN_WIDTH-1:0]  SHIN_RESET = 15'd2240;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_DIFFUSE_RED,
    REG_DIFFUSE_GREEN,
    REG_DIFFUSE_BLUE,
    REG_SPECULAR_RED,
    REG_SPECULAR_GREEN,
    REG_SPECULAR_BLUE,
    REG_SHININESS
  } cfg_reg_e;

  typedef struct packed {
    logic signed [VECTOR_WIDTH-1:0] normal_x;
    logic signed [VECTOR_WIDTH-1:0] normal_y;
    logic signed [VECTOR_WIDTH-1:0] normal_z;
    logic signed [VECTOR_WIDTH-1:0] halfway_x;
    logic signed [VECTOR_WIDTH-1:0] halfway_y;
    logic signed [VECTOR_WIDTH-1:0] halfway_z;
    logic signed [VECTOR_WIDTH-1:0] light_dir_x;
    logic signed [VECTOR_WIDTH-1:0] light_dir_y;
    logic signed [VECTOR_WIDTH-1:0] light_dir_z;
  } in_beat_t;

  typedef struct packed {
    logic [COLOR_WIDTH-1:0] out_red;
    logic [COLOR_WIDTH-1:0] out_green;
    logic [COLOR_WIDTH-1:0] out_blue;
  } out_beat_t;

  // Product of two Q1.16 values no larger than one, truncated to Q1.16.
  function automatic logic [COS_WIDTH-1:0] mul16(input logic [COS_WIDTH-1:0] a,
                                                 input logic [COS_WIDTH-1:0] b);
    logic [2*COS_WIDTH-1:0] p;
    p = a * b;
    return p[COS_WIDTH+15:16];
  endfunction

endpackage

// ===== rtl/core/bps_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Carries a side payload alongside the operand. No package dependency.
module bps_isqrt #(
  parameter int IN_W   = 64,
  parameter int SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [IN_W-1:0]     val_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [IN_W/2-1:0]   root_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int STEPS = IN_W / 2;
  localparam int RW    = STEPS + 2;

  logic              vld_q  [STEPS];
  logic [IN_W-1:0]   v_q    [STEPS];
  logic [RW-1:0]     rem_q  [STEPS];
  logic [STEPS-1:0]  root_q [STEPS];
  logic [SIDE_W-1:0] side_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic              vld_src;
    logic [IN_W-1:0]   v_src;
    logic [RW-1:0]     rem_src;
    logic [STEPS-1:0]  root_src;
    logic [SIDE_W-1:0] side_src;
    logic [RW-1:0]     rem_s;
    logic [RW-1:0]     trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign vld_src  = valid_i;
      assign v_src    = val_i;
      assign rem_src  = '0;
      assign root_src = '0;
      assign side_src = side_i;
    end else begin : g_next
      assign vld_src  = vld_q[k-1];
      assign v_src    = v_q[k-1];
      assign rem_src  = rem_q[k-1];
      assign root_src = root_q[k-1];
      assign side_src = side_q[k-1];
    end

    // Bring down the next pair of operand bits and try 4*root+1.
    always_comb begin
      rem_s = {rem_src[RW-3:0], v_src[IN_W-1 -: 2]};
      trial = {root_src, 2'b01};
      ge    = (rem_s >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k]    <= v_src << 2;
        rem_q[k]  <= ge ? (rem_s - trial) : rem_s;
        root_q[k] <= {root_src[STEPS-2:0], ge};
        side_q[k] <= side_src;
      end
    end
  end

  assign valid_o = vld_q[STEPS-1];
  assign root_o  = root_q[STEPS-1];
  assign side_o  = side_q[STEPS-1];

endmodule

// ===== rtl/core/blinn_phong_fragment_shade.sv =====
// Top level of the Blinn-Phong fragment shader: registers, datapath pipeline
// and output buffering. Depends on bps_pkg and bps_isqrt.

// The shader returns one colour beat per fragment, in order. Its pipeline
// holds four stages of vector reduction, squares, sums and the length
// product, a 32-stage square root of the product of the squared lengths, a
// 17-stage restoring divider that forms both cosines, nine stages of
// square-and-multiply for the integer part of the shininess, six rounds of a
// 17-stage square root followed by a multiply for its fractional part, and
// three stages of specular power, colour weighting and saturation. It takes
// one fragment beat per clock while the pipeline is not stalled. The result
// sits in an output register backed by a one-beat skid register; the input
// stall is that skid register's full flag, so it is a registered signal.
// While it is high the whole pipeline holds. Colour and shininess registers
// may only be rewritten while no fragment is in flight; the configuration
// port never stalls.
module blinn_phong_fragment_shade (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bps_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  logic [bps_pkg::CFG_DATA_WIDTH-1:0]  cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  bps_pkg::in_beat_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output bps_pkg::out_beat_t                  out_data_o
);
  import bps_pkg::*;

  localparam int VW          = VECTOR_WIDTH;
  localparam int CW          = COLOR_WIDTH;
  localparam int RED_SHIFT   = (VW > 16) ? VW - 16 : 0;
  localparam int LEN_SQRT_W  = 64;
  localparam int COS_SQRT_W  = 34;
  localparam int DIV_STEPS   = COS_WIDTH;
  localparam int INT_STEPS   = SHIN_WIDTH - SHIN_FRAC_BITS;
  localparam int FRAC_STEPS  = SHIN_FRAC_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always accepted.
  // ---------------------------------------------------------------------------
  logic [CW-1:0]         diffuse_q  [3];
  logic [CW-1:0]         specular_q [3];
  logic [SHIN_WIDTH-1:0] shininess_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diffuse_q[0]  <= COLOR_ONE;
      diffuse_q[1]  <= COLOR_ZERO;
      diffuse_q[2]  <= COLOR_ZERO;
      specular_q[0] <= COLOR_HALF;
      specular_q[1] <= COLOR_ONE;
      specular_q[2] <= COLOR_ONE;
      shininess_q   <= SHIN_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_DIFFUSE_RED:    diffuse_q[0]  <= cfg_data_i[CW-1:0];
        REG_DIFFUSE_GREEN:  diffuse_q[1]  <= cfg_data_i[CW-1:0];
        REG_DIFFUSE_BLUE:   diffuse_q[2]  <= cfg_data_i[CW-1:0];
        REG_SPECULAR_RED:   specular_q[0] <= cfg_data_i[CW-1:0];
        REG_SPECULAR_GREEN: specular_q[1] <= cfg_data_i[CW-1:0];
        REG_SPECULAR_BLUE:  specular_q[2] <= cfg_data_i[CW-1:0];
        REG_SHININESS:      shininess_q   <= cfg_data_i[SHIN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline advances whenever the skid register is empty.
  logic sk_v_q;
  logic en;
  assign en         = !sk_v_q;
  assign in_stall_o = sk_v_q;

  // ---------------------------------------------------------------------------
  // Stage 1: reduce each component to at most 16 magnitude bits.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic signed [16:0] nx, ny, nz, hx, hy, hz, lx, ly, lz;
  } vec9_t;

  function automatic logic signed [16:0] reduce(input logic [VW-1:0] raw);
    logic          neg;
    logic [VW:0]   mag;
    logic [VW:0]   mag_sh;
    logic [16:0]   m;
    neg    = raw[VW-1];
    mag    = neg ? ({1'b1, {VW{1'b0}}} - {1'b0, raw}) : {1'b0, raw};
    mag_sh = mag >> RED_SHIFT;
    m      = 17'(mag_sh);
    return neg ? -signed'(m) : signed'(m);
  endfunction

  vec9_t s1_q;
  logic  s1_v_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q.nx <= reduce(in_data_i.normal_x);
      s1_q.ny <= reduce(in_data_i.normal_y);
      s1_q.nz <= reduce(in_data_i.normal_z);
      s1_q.hx <= reduce(in_data_i.halfway_x);
      s1_q.hy <= reduce(in_data_i.halfway_y);
      s1_q.hz <= reduce(in_data_i.halfway_z);
      s1_q.lx <= reduce(in_data_i.light_dir_x);
      s1_q.ly <= reduce(in_data_i.light_dir_y);
      s1_q.lz <= reduce(in_data_i.light_dir_z);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: component squares and cross products.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [8:0][30:0] sq;
    logic [5:0][31:0] xp;
  } prod_t;

  function automatic logic [30:0] square(input logic signed [16:0] a);
    logic signed [33:0] p;
    p = a * a;
    return p[30:0];
  endfunction

  function automatic logic [31:0] cross_prod(input logic signed [16:0] a,
                                             input logic signed [16:0] b);
    logic signed [33:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  prod_t s2_q;
  logic  s2_v_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q.sq[0] <= square(s1_q.nx);
      s2_q.sq[1] <= square(s1_q.ny);
      s2_q.sq[2] <= square(s1_q.nz);
      s2_q.sq[3] <= square(s1_q.hx);
      s2_q.sq[4] <= square(s1_q.hy);
      s2_q.sq[5] <= square(s1_q.hz);
      s2_q.sq[6] <= square(s1_q.lx);
      s2_q.sq[7] <= square(s1_q.ly);
      s2_q.sq[8] <= square(s1_q.lz);
      s2_q.xp[0] <= cross_prod(s1_q.nx, s1_q.lx);
      s2_q.xp[1] <= cross_prod(s1_q.ny, s1_q.ly);
      s2_q.xp[2] <= cross_prod(s1_q.nz, s1_q.lz);
      s2_q.xp[3] <= cross_prod(s1_q.nx, s1_q.hx);
      s2_q.xp[4] <= cross_prod(s1_q.ny, s1_q.hy);
      s2_q.xp[5] <= cross_prod(s1_q.nz, s1_q.hz);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: squared lengths and dot products.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [31:0]        len_n, len_h, len_l;
    logic signed [33:0] d_nl, d_nh;
  } sums_t;

  sums_t s3_q;
  logic  s3_v_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q.len_n <= 32'(s2_q.sq[0]) + 32'(s2_q.sq[1]) + 32'(s2_q.sq[2]);
      s3_q.len_h <= 32'(s2_q.sq[3]) + 32'(s2_q.sq[4]) + 32'(s2_q.sq[5]);
      s3_q.len_l <= 32'(s2_q.sq[6]) + 32'(s2_q.sq[7]) + 32'(s2_q.sq[8]);
      s3_q.d_nl  <= 34'($signed(s2_q.xp[0])) + 34'($signed(s2_q.xp[1]))
                  + 34'($signed(s2_q.xp[2]));
      s3_q.d_nh  <= 34'($signed(s2_q.xp[3])) + 34'($signed(s2_q.xp[4]))
                  + 34'($signed(s2_q.xp[5]));
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: product of squared lengths and the zero-cosine flags.
  // zd: no diffuse term. zs: no specular term at all. zh: N.H cosine is zero.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [63:0] p_nl, p_nh;
    logic [31:0] d_l, d_h;
    logic        zd, zs, zh;
  } lenp_t;

  lenp_t s4_d;
  lenp_t s4_q;
  logic  s4_v_q;

  always_comb begin
    s4_d.p_nl = s3_q.len_n * s3_q.len_l;
    s4_d.p_nh = s3_q.len_n * s3_q.len_h;
    s4_d.d_l  = s3_q.d_nl[31:0];
    s4_d.d_h  = s3_q.d_nh[31:0];
    s4_d.zd   = (s3_q.len_n == '0) || (s3_q.len_l == '0) || (s3_q.d_nl <= 0);
    s4_d.zs   = (s3_q.len_n == '0) || (s3_q.len_h == '0);
    s4_d.zh   = (s3_q.d_nh <= 0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q <= s4_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Square roots of |N|^2|L|^2 and |N|^2|H|^2, run side by side.
  // ---------------------------------------------------------------------------
  logic                      rt_l_v, rt_h_v;
  logic [LEN_SQRT_W/2-1:0]   rt_l, rt_h;
  logic [32:0]               rt_l_side;
  logic [33:0]               rt_h_side;

  bps_isqrt #(
    .IN_W   (LEN_SQRT_W),
    .SIDE_W (33)
  ) u_sqrt_nl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_v_q),
    .val_i   (s4_q.p_nl),
    .side_i  ({s4_q.zd, s4_q.d_l}),
    .valid_o (rt_l_v),
    .root_o  (rt_l),
    .side_o  (rt_l_side)
  );

  bps_isqrt #(
    .IN_W   (LEN_SQRT_W),
    .SIDE_W (34)
  ) u_sqrt_nh (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_v_q),
    .val_i   (s4_q.p_nh),
    .side_i  ({s4_q.zs, s4_q.zh, s4_q.d_h}),
    .valid_o (rt_h_v),
    .root_o  (rt_h),
    .side_o  (rt_h_side)
  );

  // ---------------------------------------------------------------------------
  // Restoring divider: cosine = floor(d * 2^16 / root), one quotient bit a
  // stage. Where d is not negative it never exceeds the root, so seventeen bits hold the quotient.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [31:0] r_l, r_h, rem_l, rem_h;
    logic [16:0] q_l, q_h;
    logic        zd, zs, zh;
  } div_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [16:0] q;
  } dstep_t;

  function automatic dstep_t dstep(input logic [31:0] rem, input logic [31:0] r,
                                   input logic [16:0] q, input logic first);
    logic [32:0] t;
    logic        ge;
    dstep_t      o;
    t     = first ? {1'b0, rem} : {rem, 1'b0};
    ge    = (t >= {1'b0, r});
    o.rem = ge ? 32'(t - {1'b0, r}) : t[31:0];
    o.q   = {q[15:0], ge};
    return o;
  endfunction

  div_t div_src   [DIV_STEPS];
  logic div_src_v [DIV_STEPS];
  div_t div_q     [DIV_STEPS];
  logic div_v_q   [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    div_t   nxt;
    dstep_t st_l, st_h;

    if (k == 0) begin : g_first
      always_comb begin
        div_src[k]       = '0;
        div_src[k].r_l   = rt_l;
        div_src[k].r_h   = rt_h;
        div_src[k].rem_l = rt_l_side[31:0];
        div_src[k].rem_h = rt_h_side[31:0];
        div_src[k].zd    = rt_l_side[32];
        div_src[k].zs    = rt_h_side[33];
        div_src[k].zh    = rt_h_side[32];
      end
      assign div_src_v[k] = rt_l_v;
    end else begin : g_next
      assign div_src[k]   = div_q[k-1];
      assign div_src_v[k] = div_v_q[k-1];
    end

    always_comb begin
      st_l      = dstep(div_src[k].rem_l, div_src[k].r_l, div_src[k].q_l, 1'(k == 0));
      st_h      = dstep(div_src[k].rem_h, div_src[k].r_h, div_src[k].q_h, 1'(k == 0));
      nxt       = div_src[k];
      nxt.rem_l = st_l.rem;
      nxt.q_l   = st_l.q;
      nxt.rem_h = st_h.rem;
      nxt.q_h   = st_h.q;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[k] <= nxt;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_v_q[k] <= 1'b0;
      end else if (en) begin
        div_v_q[k] <= div_src_v[k];
      end
    end
  end

  div_t                 div_last;
  logic [COS_WIDTH-1:0] cos_d, cos_s;

  assign div_last = div_q[DIV_STEPS-1];

  always_comb begin
    cos_d = (div_last.q_l > ONE_Q16) ? ONE_Q16 : div_last.q_l;
    cos_s = (div_last.q_h > ONE_Q16) ? ONE_Q16 : div_last.q_h;
    if (div_last.zd) begin
      cos_d = '0;
    end
    if (div_last.zh) begin
      cos_s = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Integer part of the exponent: square and multiply, low bit first.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [COS_WIDTH-1:0] c, ip, base, cd;
    logic                 zs;
  } pw_t;

  pw_t  pw_src   [INT_STEPS];
  logic pw_src_v [INT_STEPS];
  pw_t  pw_q     [INT_STEPS];
  logic pw_v_q   [INT_STEPS];

  for (genvar k = 0; k < INT_STEPS; k++) begin : g_int
    if (k == 0) begin : g_first
      always_comb begin
        pw_src[k].c    = cos_s;
        pw_src[k].ip   = ONE_Q16;
        pw_src[k].base = cos_s;
        pw_src[k].cd   = cos_d;
        pw_src[k].zs   = div_last.zs;
      end
      assign pw_src_v[k] = div_v_q[DIV_STEPS-1];
    end else begin : g_next
      assign pw_src[k]   = pw_q[k-1];
      assign pw_src_v[k] = pw_v_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        pw_q[k].c    <= pw_src[k].c;
        pw_q[k].ip   <= shininess_q[SHIN_FRAC_BITS+k] ?
                        mul16(pw_src[k].ip, pw_src[k].base) : pw_src[k].ip;
        pw_q[k].base <= mul16(pw_src[k].base, pw_src[k].base);
        pw_q[k].cd   <= pw_src[k].cd;
        pw_q[k].zs   <= pw_src[k].zs;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pw_v_q[k] <= 1'b0;
      end else if (en) begin
        pw_v_q[k] <= pw_src_v[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Fractional part: repeated square roots of the cosine, each root folded in
  // when its exponent bit is set, the half-power bit first.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [COS_WIDTH-1:0] ip, fp, cd;
    logic                 zs;
  } fr_side_t;

  typedef struct packed {
    logic [COS_WIDTH-1:0] s;
    fr_side_t             side;
  } fr_t;

  fr_t                  fr_src    [FRAC_STEPS];
  logic                 fr_src_v  [FRAC_STEPS];
  fr_t                  fr_q      [FRAC_STEPS];
  logic                 fr_v_q    [FRAC_STEPS];
  logic [COS_WIDTH-1:0] fr_root   [FRAC_STEPS];
  fr_side_t             fr_rside  [FRAC_STEPS];
  logic                 fr_rv     [FRAC_STEPS];

  for (genvar j = 0; j < FRAC_STEPS; j++) begin : g_frac
    if (j == 0) begin : g_first
      always_comb begin
        fr_src[j].s       = pw_q[INT_STEPS-1].c;
        fr_src[j].side.ip = pw_q[INT_STEPS-1].ip;
        fr_src[j].side.fp = ONE_Q16;
        fr_src[j].side.cd = pw_q[INT_STEPS-1].cd;
        fr_src[j].side.zs = pw_q[INT_STEPS-1].zs;
      end
      assign fr_src_v[j] = pw_v_q[INT_STEPS-1];
    end else begin : g_next
      assign fr_src[j]   = fr_q[j-1];
      assign fr_src_v[j] = fr_v_q[j-1];
    end

    bps_isqrt #(
      .IN_W   (COS_SQRT_W),
      .SIDE_W ($bits(fr_side_t))
    ) u_sqrt_frac (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (fr_src_v[j]),
      .val_i   (COS_SQRT_W'({fr_src[j].s, 16'b0})),
      .side_i  (fr_src[j].side),
      .valid_o (fr_rv[j]),
      .root_o  (fr_root[j]),
      .side_o  (fr_rside[j])
    );

    always_ff @(posedge clk_i) begin
      if (en) begin
        fr_q[j].s       <= fr_root[j];
        fr_q[j].side.ip <= fr_rside[j].ip;
        fr_q[j].side.fp <= shininess_q[SHIN_FRAC_BITS-1-j] ?
                           mul16(fr_rside[j].fp, fr_root[j]) : fr_rside[j].fp;
        fr_q[j].side.cd <= fr_rside[j].cd;
        fr_q[j].side.zs <= fr_rside[j].zs;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fr_v_q[j] <= 1'b0;
      end else if (en) begin
        fr_v_q[j] <= fr_rv[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Final stages: specular power, colour weighting, shift and saturation.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [COS_WIDTH-1:0] spec, cd;
  } terms_t;

  typedef struct packed {
    logic [2:0][CW+COS_WIDTH-1:0] dp, sp;
  } wprod_t;

  fr_side_t  fr_last;
  terms_t    f1_q;
  logic      f1_v_q;
  wprod_t    f2_d, f2_q;
  logic      f2_v_q;
  out_beat_t f3_d, f3_q;
  logic      f3_v_q;

  assign fr_last = fr_q[FRAC_STEPS-1].side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f2_d.dp[i] = diffuse_q[i] * f1_q.cd;
      f2_d.sp[i] = specular_q[i] * f1_q.spec;
    end
  end

  always_comb begin
    logic [CW+COS_WIDTH:0]   sum;
    logic [CW:0]             shade;
    logic [2:0][CW-1:0]      chan;
    for (int i = 0; i < 3; i++) begin
      sum     = (CW+COS_WIDTH+1)'(f2_q.dp[i]) + (CW+COS_WIDTH+1)'(f2_q.sp[i]);
      shade   = sum[CW+COS_WIDTH:COS_WIDTH];
      chan[i] = shade[CW] ? {CW{1'b1}} : shade[CW-1:0];
    end
    f3_d.out_red   = chan[0];
    f3_d.out_green = chan[1];
    f3_d.out_blue  = chan[2];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_q.spec <= fr_last.zs ? '0 : mul16(fr_last.ip, fr_last.fp);
      f1_q.cd   <= fr_last.cd;
      f2_q      <= f2_d;
      f3_q      <= f3_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
    end else if (en) begin
      f1_v_q <= fr_v_q[FRAC_STEPS-1];
      f2_v_q <= f1_v_q;
      f3_v_q <= f2_v_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with a one-beat skid. A beat leaving the pipeline while
  // the output is stalled parks in the skid register, which then holds the
  // pipeline until the output drains.
  // ---------------------------------------------------------------------------
  logic      out_v_q;
  out_beat_t out_q;
  out_beat_t sk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (sk_v_q) begin
      if (!out_stall_i) begin
        sk_v_q <= 1'b0;
      end
    end else if (out_v_q && out_stall_i) begin
      if (f3_v_q) begin
        sk_v_q <= 1'b1;
      end
    end else begin
      out_v_q <= f3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_v_q) begin
      if (!out_stall_i) begin
        out_q <= sk_q;
      end
    end else if (out_v_q && out_stall_i) begin
      sk_q <= f3_q;
    end else begin
      out_q <= f3_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q |-> out_v_q)
    else $error("skid register holds a beat while the output register is empty");

  a_skid_fill_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sk_v_q) |-> $past(out_stall_i) && $past(out_v_q))
    else $error("skid register filled without a stalled output beat");

  a_roots_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rt_l_v == rt_h_v)
    else $error("the two length square roots lost alignment");

  a_cosine_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_v_q[DIV_STEPS-1] && !div_last.zd |-> div_last.q_l <= ONE_Q16)
    else $error("diffuse cosine quotient exceeds one");

endmodule
